// ----- hw/rtl/pdfd_pkg.sv -----
// ----------------------------------------------------------------------------
// pdfd_pkg
// shared types and constants of the optical delta frame decoder
// ----------------------------------------------------------------------------
`default_nettype none

package pdfd_pkg;

    // defaults for the top level parameters
    localparam int REF_BYTES_DEF      = 3;
    localparam int MAX_DELTA_BITS_DEF = 32;
    localparam int QUEUE_DEPTH_DEF    = 4;

    // header layout
    localparam int          CHANNELS      = 4;
    localparam logic [5:0]  MEAS_TYPE     = 6'h01;
    localparam logic [4:0]  STAMP_LAST    = 5'd8;
    localparam logic [4:0]  FRAME_POS     = 5'd9;
    localparam logic [4:0]  REF_FIRST_POS = 5'd10;

    // result kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_ERROR  = 1'b1;

    // error codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_FRAME = 2'd1;
    localparam logic [1:0] ERR_RAW   = 2'd2;
    localparam logic [1:0] ERR_SIZE  = 2'd3;

    // work handed from the front part to the back part
    typedef enum logic [2:0] {
        OP_NOP,
        OP_CLEAR,
        OP_STAMP,
        OP_REF,
        OP_FSIZE,
        OP_COUNT,
        OP_DATA,
        OP_ERR
    } op_code_t;

    typedef struct packed {
        op_code_t   op;
        logic [7:0] data;
        logic [2:0] lane;       // stamp byte lane or reference byte lane
        logic [1:0] chan;       // reference channel
        logic [1:0] code;       // error code of an error op
        logic       short_err;  // packet ended inside the header
        logic       last;       // item carried the end mark
    } op_t;

    typedef enum logic [1:0] {
        FM_HEADER,
        FM_RAWHDR,
        FM_SKIP,
        FM_PAYLOAD
    } front_mode_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_EXTRACT,
        BK_SHORT
    } back_state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ppg_delta_frame_decoder.sv -----
// ----------------------------------------------------------------------------
// ppg_delta_frame_decoder
// decodes 4-channel optical packets with bit-packed deltas, one byte per item
// ----------------------------------------------------------------------------
// a header result passes through the op queue and the result register; a delta sample
// also passes through the BK_EXTRACT state, which holds the back end on a delta byte
//   until the deltas it completes are unpacked, one delta per cycle while the result
//   register can take each finished sample; a short-packet report passes through BK_SHORT
// the op queue (4 entries by default) keeps s_ready high while the back end unpacks, until it fills
// reset: synchronous, active low; clears queue, parser and result valid
`default_nettype none

module ppg_delta_frame_decoder #(
    parameter int REF_BYTES      = pdfd_pkg::REF_BYTES_DEF,
    parameter int MAX_DELTA_BITS = pdfd_pkg::MAX_DELTA_BITS_DEF,
    parameter int QUEUE_DEPTH    = pdfd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    // byte items in
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic [7:0]    s_data_byte,
    input  wire logic          s_packet_end,
    // result items out
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic               m_kind,
    output logic [1:0]         m_error_code,
    output logic [63:0]        m_stamp,
    output logic [7:0]         m_sample_index,
    output logic signed [31:0] m_green_value,
    output logic signed [31:0] m_red_value,
    output logic signed [31:0] m_infrared_value,
    output logic signed [31:0] m_ambient_value,
    output logic               m_run_last
);

    // front to queue
    logic          push_valid;
    logic          push_ready;
    pdfd_pkg::op_t push_entry;

    // queue to back
    logic          pop_valid;
    logic          pop_ready;
    pdfd_pkg::op_t pop_entry;

    // header parsing and byte classification
    pdfd_front #(
        .REF_BYTES      (REF_BYTES),
        .MAX_DELTA_BITS (MAX_DELTA_BITS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_packet_end (s_packet_end),
        .q_valid      (push_valid),
        .q_ready      (push_ready),
        .q_entry      (push_entry)
    );

    // decouples parsing from unpacking so each side can stall alone
    pdfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    // timestamp, references, delta unpacking and the result register
    pdfd_back #(
        .REF_BYTES (REF_BYTES)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_valid          (pop_valid),
        .q_ready          (pop_ready),
        .q_entry          (pop_entry),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kind           (m_kind),
        .m_error_code     (m_error_code),
        .m_stamp          (m_stamp),
        .m_sample_index   (m_sample_index),
        .m_green_value    (m_green_value),
        .m_red_value      (m_red_value),
        .m_infrared_value (m_infrared_value),
        .m_ambient_value  (m_ambient_value),
        .m_run_last       (m_run_last)
    );

`ifndef ASSERT_OFF
    // the front only queues an op when the queue has room
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push_valid |-> push_ready)
        else $error("op pushed into a full queue");

    // an error report is always the last result of its item
    a_error_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind) |-> m_run_last)
        else $error("error report not marked last");

    // error reports carry zero index and values, samples carry no code
    a_error_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_kind ? (m_sample_index == 8'd0 && m_green_value == 32'sd0 &&
                               m_red_value == 32'sd0 && m_infrared_value == 32'sd0 &&
                               m_ambient_value == 32'sd0)
                            : (m_error_code == pdfd_pkg::ERR_NONE)))
        else $error("result payload does not match its kind");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/pdfd_front.sv -----
// ----------------------------------------------------------------------------
// pdfd_front
// header parser: classifies each byte and queues an op for the back part
// ----------------------------------------------------------------------------
`default_nettype none

module pdfd_front #(
    parameter int REF_BYTES      = pdfd_pkg::REF_BYTES_DEF,
    parameter int MAX_DELTA_BITS = pdfd_pkg::MAX_DELTA_BITS_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [7:0]       s_data_byte,
    input  wire logic             s_packet_end,
    output logic                  q_valid,
    input  wire logic             q_ready,
    output pdfd_pkg::op_t         q_entry
);

    localparam logic [4:0] FS_POS    = 5'(10 + pdfd_pkg::CHANNELS * REF_BYTES);
    localparam logic [4:0] COUNT_POS = FS_POS + 5'd1;
    localparam logic [1:0] LANE_LAST = 2'(REF_BYTES - 1);

    pdfd_pkg::front_mode_t mode_reg, mode_next;
    logic [4:0]            pos_reg, pos_next;
    logic [1:0]            lane_reg, lane_next;
    logic [1:0]            chan_reg, chan_next;

    logic accept;
    logic push;

    assign s_ready = q_ready;
    assign accept  = s_valid && q_ready;
    assign q_valid = accept && push;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= pdfd_pkg::FM_HEADER;
            pos_reg  <= '0;
            lane_reg <= '0;
            chan_reg <= '0;
        end else begin
            mode_reg <= mode_next;
            pos_reg  <= pos_next;
            lane_reg <= lane_next;
            chan_reg <= chan_next;
        end
    end

    always_comb begin
        mode_next = mode_reg;
        pos_next  = pos_reg;
        lane_next = lane_reg;
        chan_next = chan_reg;
        push      = 1'b0;

        q_entry           = '0;
        q_entry.op        = pdfd_pkg::OP_NOP;
        q_entry.data      = s_data_byte;
        q_entry.last      = s_packet_end;
        q_entry.short_err = s_packet_end;

        if (accept) begin
            case (mode_reg)
                pdfd_pkg::FM_HEADER, pdfd_pkg::FM_RAWHDR: begin
                    push = 1'b1;
                    if (pos_reg == 5'd0) begin
                        q_entry.op = pdfd_pkg::OP_CLEAR;
                        lane_next  = '0;
                        chan_next  = '0;
                        if (s_data_byte[5:0] != pdfd_pkg::MEAS_TYPE) begin
                            mode_next         = pdfd_pkg::FM_SKIP;
                            q_entry.short_err = 1'b0;
                        end else if (s_data_byte[7]) begin
                            mode_next = pdfd_pkg::FM_HEADER;
                        end else begin
                            mode_next = pdfd_pkg::FM_RAWHDR;
                        end
                    end else if (pos_reg <= pdfd_pkg::STAMP_LAST) begin
                        q_entry.op   = pdfd_pkg::OP_STAMP;
                        q_entry.lane = 3'(pos_reg - 5'd1);
                    end else if (pos_reg == pdfd_pkg::FRAME_POS) begin
                        if (s_data_byte[6:0] != 7'd0) begin
                            q_entry.op        = pdfd_pkg::OP_ERR;
                            q_entry.code      = pdfd_pkg::ERR_FRAME;
                            q_entry.short_err = 1'b0;
                            mode_next         = pdfd_pkg::FM_SKIP;
                        end else if (mode_reg == pdfd_pkg::FM_RAWHDR) begin
                            q_entry.op        = pdfd_pkg::OP_ERR;
                            q_entry.code      = pdfd_pkg::ERR_RAW;
                            q_entry.short_err = 1'b0;
                            mode_next         = pdfd_pkg::FM_SKIP;
                        end else begin
                            // nothing to do unless the packet ends here
                            push = s_packet_end;
                        end
                    end else if (pos_reg < FS_POS) begin
                        q_entry.op   = pdfd_pkg::OP_REF;
                        q_entry.lane = {1'b0, lane_reg};
                        q_entry.chan = chan_reg;
                        if (lane_reg == LANE_LAST) begin
                            lane_next = '0;
                            chan_next = chan_reg + 2'd1;
                        end else begin
                            lane_next = lane_reg + 2'd1;
                        end
                    end else if (pos_reg == FS_POS) begin
                        if (s_data_byte == 8'd0 || s_data_byte > 8'(MAX_DELTA_BITS)) begin
                            q_entry.op        = pdfd_pkg::OP_ERR;
                            q_entry.code      = pdfd_pkg::ERR_SIZE;
                            q_entry.short_err = 1'b0;
                            mode_next         = pdfd_pkg::FM_SKIP;
                        end else begin
                            q_entry.op = pdfd_pkg::OP_FSIZE;
                        end
                    end else begin
                        // sample count byte: the reference sample goes out here
                        q_entry.op        = pdfd_pkg::OP_COUNT;
                        q_entry.short_err = s_packet_end && (s_data_byte != 8'd0);
                        mode_next = (s_data_byte == 8'd0) ? pdfd_pkg::FM_SKIP
                                                           : pdfd_pkg::FM_PAYLOAD;
                    end
                    if (pos_reg != COUNT_POS) begin
                        pos_next = pos_reg + 5'd1;
                    end
                end
                pdfd_pkg::FM_PAYLOAD: begin
                    push              = 1'b1;
                    q_entry.op        = pdfd_pkg::OP_DATA;
                    q_entry.short_err = 1'b0;
                end
                default: begin
                    push = 1'b0;
                end
            endcase

            if (s_packet_end) begin
                mode_next = pdfd_pkg::FM_HEADER;
                pos_next  = '0;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/pdfd_queue.sv -----
// ----------------------------------------------------------------------------
// pdfd_queue
// short op queue between the front and back parts
// ----------------------------------------------------------------------------
`default_nettype none

module pdfd_queue #(
    parameter int DEPTH = pdfd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push_valid,
    output logic               push_ready,
    input  wire pdfd_pkg::op_t push_entry,
    output logic               pop_valid,
    input  wire logic          pop_ready,
    output pdfd_pkg::op_t      pop_entry
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

    pdfd_pkg::op_t slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] fill_reg;

    logic do_push, do_pop;

    assign push_ready = (fill_reg != CW'(DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_entry  = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop) begin
                fill_reg <= fill_reg + CW'(1);
            end else if (do_pop && !do_push) begin
                fill_reg <= fill_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/pdfd_back.sv -----
// ----------------------------------------------------------------------------
// pdfd_back
// executes queued ops: timestamp, reference values, delta unpacking, results
// ----------------------------------------------------------------------------
`default_nettype none

module pdfd_back #(
    parameter int REF_BYTES = pdfd_pkg::REF_BYTES_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          q_valid,
    output logic               q_ready,
    input  wire pdfd_pkg::op_t q_entry,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic               m_kind,
    output logic [1:0]         m_error_code,
    output logic [63:0]        m_stamp,
    output logic [7:0]         m_sample_index,
    output logic signed [31:0] m_green_value,
    output logic signed [31:0] m_red_value,
    output logic signed [31:0] m_infrared_value,
    output logic signed [31:0] m_ambient_value,
    output logic               m_run_last
);

    localparam int          NCH       = pdfd_pkg::CHANNELS;
    localparam int          REF_W     = 8 * REF_BYTES;
    localparam logic [31:0] REF_MASK  = 32'((64'd1 << REF_W) - 64'd1);
    localparam logic [1:0]  LANE_LAST = 2'(REF_BYTES - 1);

    pdfd_pkg::back_state_t state_reg, state_next;
    logic [63:0] stamp_reg, stamp_next;
    logic [31:0] sums_reg [NCH];
    logic [31:0] sums_next [NCH];
    logic [5:0]  delta_bits_reg, delta_bits_next;
    logic [7:0]  samples_left_reg, samples_left_next;
    logic [7:0]  sample_counter_reg, sample_counter_next;
    logic [39:0] bit_buffer_reg, bit_buffer_next;
    logic [5:0]  bits_held_reg, bits_held_next;
    logic [1:0]  cursor_reg, cursor_next;
    logic        active_reg, active_next;
    logic        last_pend_reg, last_pend_next;

    // result register
    logic        m_valid_reg;
    logic        kind_reg;
    logic [1:0]  code_reg;
    logic [63:0] stamp_out_reg;
    logic [7:0]  index_reg;
    logic [31:0] value_reg [NCH];
    logic        run_last_reg;

    logic        out_free;
    logic        out_load;
    logic        out_kind;
    logic [1:0]  out_code;
    logic [7:0]  out_index;
    logic        out_run_last;

    // datapath terms
    logic [39:0] buf_fill;
    logic [5:0]  held_fill;
    logic [31:0] low_word;
    logic [31:0] delta_mask;
    logic [5:0]  delta_m1;
    logic [31:0] delta_val;
    logic [39:0] buf_shift;
    logic [5:0]  held_shift;
    logic        more_sample;
    logic [31:0] ref_val [NCH];

    assign out_free = !m_valid_reg || m_ready;

    assign buf_fill    = bit_buffer_reg | (40'(q_entry.data) << bits_held_reg);
    assign held_fill   = bits_held_reg + 6'd8;
    assign low_word    = bit_buffer_reg[31:0];
    assign delta_mask  = ~(32'hFFFF_FFFF << delta_bits_reg);
    assign delta_m1    = delta_bits_reg - 6'd1;
    assign delta_val   = low_word[delta_m1[4:0]] ? (low_word | ~delta_mask)
                                                 : (low_word & delta_mask);
    assign buf_shift   = bit_buffer_reg >> delta_bits_reg;
    assign held_shift  = bits_held_reg - delta_bits_reg;
    // enough bits left for four more deltas
    assign more_sample = ({2'b00, held_shift} >= {delta_bits_reg, 2'b00});

    // reference byte assembly: the current lane merged into each channel's value
    always_comb begin
        logic [31:0] raw;
        for (int c = 0; c < NCH; c++) begin
            if (q_entry.lane[1:0] == 2'd0) begin
                raw = {24'd0, q_entry.data};
            end else begin
                raw = sums_reg[c] | (32'(q_entry.data) << {q_entry.lane[1:0], 3'b000});
            end
            if (q_entry.lane[1:0] == LANE_LAST) begin
                raw = raw[REF_W-1] ? (raw | ~REF_MASK) : (raw & REF_MASK);
            end
            ref_val[c] = raw;
        end
    end

    always_comb begin
        state_next          = state_reg;
        stamp_next          = stamp_reg;
        sums_next           = sums_reg;
        delta_bits_next     = delta_bits_reg;
        samples_left_next   = samples_left_reg;
        sample_counter_next = sample_counter_reg;
        bit_buffer_next     = bit_buffer_reg;
        bits_held_next      = bits_held_reg;
        cursor_next         = cursor_reg;
        active_next         = active_reg;
        last_pend_next      = last_pend_reg;
        q_ready             = 1'b0;
        out_load            = 1'b0;
        out_kind            = pdfd_pkg::KIND_SAMPLE;
        out_code            = pdfd_pkg::ERR_NONE;
        out_index           = 8'd0;
        out_run_last        = 1'b1;

        case (state_reg)
            pdfd_pkg::BK_IDLE: begin
                if (q_valid) begin
                    case (q_entry.op)
                        pdfd_pkg::OP_CLEAR: begin
                            q_ready    = 1'b1;
                            stamp_next = '0;
                        end
                        pdfd_pkg::OP_STAMP: begin
                            q_ready    = 1'b1;
                            stamp_next = stamp_reg |
                                         (64'(q_entry.data) << {q_entry.lane, 3'b000});
                        end
                        pdfd_pkg::OP_REF: begin
                            q_ready = 1'b1;
                            for (int c = 0; c < NCH; c++) begin
                                if (q_entry.chan == 2'(c)) begin
                                    sums_next[c] = ref_val[c];
                                end
                            end
                        end
                        pdfd_pkg::OP_FSIZE: begin
                            q_ready         = 1'b1;
                            delta_bits_next = q_entry.data[5:0];
                        end
                        pdfd_pkg::OP_ERR: begin
                            if (out_free) begin
                                q_ready  = 1'b1;
                                out_load = 1'b1;
                                out_kind = pdfd_pkg::KIND_ERROR;
                                out_code = q_entry.code;
                            end
                        end
                        pdfd_pkg::OP_COUNT: begin
                            if (out_free) begin
                                q_ready             = 1'b1;
                                out_load            = 1'b1;
                                out_run_last        = !q_entry.short_err;
                                samples_left_next   = q_entry.data;
                                sample_counter_next = '0;
                                bit_buffer_next     = '0;
                                bits_held_next      = '0;
                                cursor_next         = '0;
                                active_next = (q_entry.data != 8'd0) && !q_entry.last;
                            end
                        end
                        pdfd_pkg::OP_DATA: begin
                            q_ready = 1'b1;
                            if (active_reg) begin
                                bit_buffer_next = buf_fill;
                                bits_held_next  = held_fill;
                                if (held_fill >= delta_bits_reg) begin
                                    state_next     = pdfd_pkg::BK_EXTRACT;
                                    last_pend_next = q_entry.last;
                                end else if (q_entry.last) begin
                                    state_next = pdfd_pkg::BK_SHORT;
                                end
                            end
                        end
                        default: begin
                            q_ready = 1'b1;
                        end
                    endcase
                    // header cut short: report once this op is done
                    if (q_ready && q_entry.short_err) begin
                        state_next = pdfd_pkg::BK_SHORT;
                    end
                end
            end

            pdfd_pkg::BK_EXTRACT: begin
                if (cursor_reg != 2'd3 || out_free) begin
                    bit_buffer_next = buf_shift;
                    bits_held_next  = held_shift;
                    cursor_next     = cursor_reg + 2'd1;
                    for (int c = 0; c < NCH; c++) begin
                        if (cursor_reg == 2'(c)) begin
                            sums_next[c] = sums_reg[c] + delta_val;
                        end
                    end
                    if (cursor_reg == 2'd3) begin
                        sample_counter_next = sample_counter_reg + 8'd1;
                        samples_left_next   = samples_left_reg - 8'd1;
                        out_load            = 1'b1;
                        out_index           = sample_counter_reg + 8'd1;
                        if (samples_left_reg == 8'd1) begin
                            active_next  = 1'b0;
                            out_run_last = 1'b1;
                        end else begin
                            out_run_last = !(more_sample || last_pend_reg);
                        end
                    end
                    if (active_next && held_shift >= delta_bits_reg) begin
                        state_next = pdfd_pkg::BK_EXTRACT;
                    end else if (last_pend_reg && active_next) begin
                        state_next = pdfd_pkg::BK_SHORT;
                    end else begin
                        state_next = pdfd_pkg::BK_IDLE;
                        if (last_pend_reg) begin
                            active_next = 1'b0;
                        end
                    end
                end
            end

            pdfd_pkg::BK_SHORT: begin
                if (out_free) begin
                    out_load    = 1'b1;
                    out_kind    = pdfd_pkg::KIND_ERROR;
                    out_code    = pdfd_pkg::ERR_SIZE;
                    active_next = 1'b0;
                    state_next  = pdfd_pkg::BK_IDLE;
                end
            end

            default: begin
                state_next = pdfd_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= pdfd_pkg::BK_IDLE;
            active_reg    <= 1'b0;
            last_pend_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            last_pend_reg <= last_pend_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        stamp_reg          <= stamp_next;
        sums_reg           <= sums_next;
        delta_bits_reg     <= delta_bits_next;
        samples_left_reg   <= samples_left_next;
        sample_counter_reg <= sample_counter_next;
        bit_buffer_reg     <= bit_buffer_next;
        bits_held_reg      <= bits_held_next;
        cursor_reg         <= cursor_next;
        if (out_load) begin
            kind_reg      <= out_kind;
            code_reg      <= out_code;
            stamp_out_reg <= stamp_next;
            index_reg     <= out_index;
            run_last_reg  <= out_run_last;
            for (int c = 0; c < NCH; c++) begin
                value_reg[c] <= (out_kind == pdfd_pkg::KIND_ERROR) ? 32'd0 : sums_next[c];
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_kind           = kind_reg;
    assign m_error_code     = code_reg;
    assign m_stamp          = stamp_out_reg;
    assign m_sample_index   = index_reg;
    assign m_green_value    = value_reg[0];
    assign m_red_value      = value_reg[1];
    assign m_infrared_value = value_reg[2];
    assign m_ambient_value  = value_reg[3];
    assign m_run_last       = run_last_reg;

endmodule

`default_nettype wire

// ----- sim/ppg_delta_frame_decoder_test.sv -----
// ----------------------------------------------------------------------------
// ppg_delta_frame_decoder_test
// drives byte items into the optical delta frame decoder and checks every
// decoded sample and error report against a cycle-free packet decoder
// ----------------------------------------------------------------------------

module ppg_delta_frame_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REF_LEN   = pdfd_pkg::REF_BYTES_DEF;
    localparam int MAX_BITS  = pdfd_pkg::MAX_DELTA_BITS_DEF;
    localparam int SIZE_POS  = pdfd_pkg::REF_FIRST_POS + pdfd_pkg::CHANNELS * REF_LEN;
    localparam int COUNT_POS = SIZE_POS + 1;

    localparam int TOTAL_ITEMS = 460;
    localparam int LIMIT       = 400000;
    localparam int LONG_HOLD   = 300;

    typedef struct packed {
        logic        kind;
        logic [1:0]  code;
        logic [63:0] stamp;
        logic [7:0]  sample_no;
        logic [31:0] green;
        logic [31:0] red;
        logic [31:0] infrared;
        logic [31:0] ambient;
        logic        run_last;
    } ppg_result_t;

    class ppg_frame_scoreboard;
        // decoder state
        pdfd_pkg::front_mode_t parse_mode;
        logic [4:0]  hdr_pos;
        logic [63:0] stamp_acc;
        logic [31:0] sums [4];
        logic [5:0]  width;
        logic [7:0]  samples_left;
        logic [39:0] pool;
        logic [5:0]  pool_bits;
        logic [1:0]  chan;
        logic [7:0]  sample_no;

        ppg_result_t pending_results[$];
        ppg_result_t batch[$];
        int          fail_count;

        function new();
            parse_mode   = pdfd_pkg::FM_HEADER;
            hdr_pos      = '0;
            stamp_acc    = '0;
            foreach (sums[i]) sums[i] = '0;
            width        = '0;
            samples_left = '0;
            pool         = '0;
            pool_bits    = '0;
            chan         = '0;
            sample_no    = '0;
            fail_count   = 0;
        endfunction

        function logic [31:0] extend(logic [63:0] v, int w);
            logic [63:0] m;
            m = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
            v = v & m;
            if (v[w-1])
                v = v | ~m;
            return v[31:0];
        endfunction

        function void add_result(logic kind, logic [1:0] code, logic [7:0] idx);
            ppg_result_t r;
            r.kind      = kind;
            r.code      = code;
            r.stamp     = stamp_acc;
            r.sample_no = (kind == pdfd_pkg::KIND_ERROR) ? 8'd0 : idx;
            r.green     = (kind == pdfd_pkg::KIND_ERROR) ? 32'd0 : sums[0];
            r.red       = (kind == pdfd_pkg::KIND_ERROR) ? 32'd0 : sums[1];
            r.infrared  = (kind == pdfd_pkg::KIND_ERROR) ? 32'd0 : sums[2];
            r.ambient   = (kind == pdfd_pkg::KIND_ERROR) ? 32'd0 : sums[3];
            r.run_last  = 1'b0;
            batch.push_back(r);
        endfunction

        // one accepted byte item: update the decoder and queue what it emits
        function void note_byte(logic [7:0] b, logic last);
            bit          errored;
            int          p;
            int          rel;
            int          ch;
            int          lane;
            logic [63:0] wide;
            errored = 0;
            batch.delete();
            if (parse_mode == pdfd_pkg::FM_HEADER || parse_mode == pdfd_pkg::FM_RAWHDR) begin
                p = hdr_pos;
                if (p == 0) begin
                    stamp_acc = '0;
                    if (b[5:0] != pdfd_pkg::MEAS_TYPE)
                        parse_mode = pdfd_pkg::FM_SKIP;
                    else
                        parse_mode = b[7] ? pdfd_pkg::FM_HEADER : pdfd_pkg::FM_RAWHDR;
                end else if (p <= pdfd_pkg::STAMP_LAST) begin
                    stamp_acc[8*(p-1) +: 8] = b;
                end else if (p == pdfd_pkg::FRAME_POS) begin
                    if (b[6:0] != 7'd0) begin
                        add_result(pdfd_pkg::KIND_ERROR, pdfd_pkg::ERR_FRAME, 8'd0);
                        errored    = 1;
                        parse_mode = pdfd_pkg::FM_SKIP;
                    end else if (parse_mode == pdfd_pkg::FM_RAWHDR) begin
                        add_result(pdfd_pkg::KIND_ERROR, pdfd_pkg::ERR_RAW, 8'd0);
                        errored    = 1;
                        parse_mode = pdfd_pkg::FM_SKIP;
                    end
                end else if (p < SIZE_POS) begin
                    rel  = p - pdfd_pkg::REF_FIRST_POS;
                    ch   = rel / REF_LEN;
                    lane = rel % REF_LEN;
                    if (lane == 0)
                        sums[ch] = {24'd0, b};
                    else
                        sums[ch][8*lane +: 8] = b;
                    if (lane == REF_LEN - 1)
                        sums[ch] = extend({32'd0, sums[ch]}, 8 * REF_LEN);
                end else if (p == SIZE_POS) begin
                    if (b == 8'd0 || b > MAX_BITS) begin
                        add_result(pdfd_pkg::KIND_ERROR, pdfd_pkg::ERR_SIZE, 8'd0);
                        errored    = 1;
                        parse_mode = pdfd_pkg::FM_SKIP;
                    end else begin
                        width = b[5:0];
                    end
                end else begin
                    add_result(pdfd_pkg::KIND_SAMPLE, pdfd_pkg::ERR_NONE, 8'd0);
                    samples_left = b;
                    sample_no    = '0;
                    pool         = '0;
                    pool_bits    = '0;
                    chan         = '0;
                    parse_mode   = (b == 8'd0) ? pdfd_pkg::FM_SKIP : pdfd_pkg::FM_PAYLOAD;
                end
                if (parse_mode == pdfd_pkg::FM_HEADER || parse_mode == pdfd_pkg::FM_RAWHDR)
                    hdr_pos = 5'(p + 1);
            end else if (parse_mode == pdfd_pkg::FM_PAYLOAD) begin
                wide      = {24'd0, pool} | ({56'd0, b} << pool_bits);
                pool      = wide[39:0];
                pool_bits = pool_bits + 6'd8;
                while (parse_mode == pdfd_pkg::FM_PAYLOAD && width != 0 &&
                       pool_bits >= width) begin
                    sums[chan] = sums[chan] + extend({24'd0, pool}, width);
                    pool       = pool >> width;
                    pool_bits  = pool_bits - width;
                    chan       = chan + 2'd1;
                    if (chan == 2'd0) begin
                        sample_no = sample_no + 8'd1;
                        add_result(pdfd_pkg::KIND_SAMPLE, pdfd_pkg::ERR_NONE, sample_no);
                        samples_left = samples_left - 8'd1;
                        if (samples_left == 8'd0)
                            parse_mode = pdfd_pkg::FM_SKIP;
                    end
                end
            end

            if (last) begin
                if (!errored && (parse_mode == pdfd_pkg::FM_HEADER ||
                                 parse_mode == pdfd_pkg::FM_RAWHDR ||
                                 (parse_mode == pdfd_pkg::FM_PAYLOAD && samples_left != 8'd0)))
                    add_result(pdfd_pkg::KIND_ERROR, pdfd_pkg::ERR_SIZE, 8'd0);
                hdr_pos    = '0;
                parse_mode = pdfd_pkg::FM_HEADER;
            end

            if (batch.size() > 0)
                batch[batch.size()-1].run_last = 1'b1;
            foreach (batch[i])
                pending_results.push_back(batch[i]);
        endfunction

        task report(string what);
            if (fail_count < 40)
                $display("mismatch: %s", what);
            fail_count++;
        endtask

        task compare(string field, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                report($sformatf("%s got %0h want %0h", field, got, want));
        endtask

        task check_result(ppg_result_t got);
            ppg_result_t want;
            if (pending_results.size() == 0) begin
                report($sformatf("result with nothing expected, kind %0d index %0d",
                                 got.kind, got.sample_no));
                return;
            end
            want = pending_results.pop_front();
            compare("kind", got.kind, want.kind);
            compare("error_code", got.code, want.code);
            compare("stamp", got.stamp, want.stamp);
            compare("sample_index", got.sample_no, want.sample_no);
            compare("green_value", got.green, want.green);
            compare("red_value", got.red, want.red);
            compare("infrared_value", got.infrared, want.infrared);
            compare("ambient_value", got.ambient, want.ambient);
            compare("run_last", got.run_last, want.run_last);
        endtask

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic               aclk         = 1'b0;
    logic               aresetn      = 1'b0;
    logic               s_valid      = 1'b0;
    logic               s_ready;
    logic [7:0]         s_data_byte  = '0;
    logic               s_packet_end = 1'b0;
    logic               m_valid;
    logic               m_ready      = 1'b0;
    logic               m_kind;
    logic [1:0]         m_error_code;
    logic [63:0]        m_stamp;
    logic [7:0]         m_sample_index;
    logic signed [31:0] m_green_value;
    logic signed [31:0] m_red_value;
    logic signed [31:0] m_infrared_value;
    logic signed [31:0] m_ambient_value;
    logic               m_run_last;

    ppg_frame_scoreboard sb;
    logic [7:0]          pkt[$];
    int                  items_sent    = 0;
    int                  src_idle_pct  = 31;
    int                  sink_idle_pct = 57;
    logic                long_hold_req = 1'b0;
    int                  cycle_count   = 0;

    ppg_delta_frame_decoder u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_packet_end     (s_packet_end),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kind           (m_kind),
        .m_error_code     (m_error_code),
        .m_stamp          (m_stamp),
        .m_sample_index   (m_sample_index),
        .m_green_value    (m_green_value),
        .m_red_value      (m_red_value),
        .m_infrared_value (m_infrared_value),
        .m_ambient_value  (m_ambient_value),
        .m_run_last       (m_run_last)
    );

    always #5 aclk = ~aclk;

    // watchdog on the whole run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("FAIL ppg_delta_frame_decoder");
            $finish;
        end
    end

    // byte values leaning toward the sign and range corners
    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h80;
            3:       return 8'h7F;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic void trim_to(int n);
        while (pkt.size() > n)
            void'(pkt.pop_back());
    endfunction

    // one packet: mostly well formed with random content, the rest broken
    function automatic void make_packet();
        int         size;
        int         count;
        int         need;
        int         sel;
        logic [7:0] b0;
        pkt.delete();
        sel = $urandom_range(0, 99);
        case ($urandom_range(0, 5))
            0:       size = 1;
            1:       size = MAX_BITS;
            default: size = $urandom_range(1, MAX_BITS);
        endcase
        count = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 4);
        // long count that ends early, packed tightly
        if (sel >= 94) begin
            size  = $urandom_range(1, 2);
            count = $urandom_range(200, 255);
        end
        pkt.push_back({1'b1, 1'($urandom), pdfd_pkg::MEAS_TYPE});
        repeat (8) pkt.push_back(rand_byte());
        pkt.push_back($urandom_range(0, 1) ? 8'h80 : 8'h00);
        repeat (pdfd_pkg::CHANNELS * REF_LEN) pkt.push_back(rand_byte());
        pkt.push_back(8'(size));
        pkt.push_back(8'(count));
        need = (size * pdfd_pkg::CHANNELS * count + 7) / 8;
        if (need > 48)
            need = 48;
        repeat (need) pkt.push_back(rand_byte());
        // bytes past the last sample are ignored
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) pkt.push_back(8'($urandom));

        if (sel < 60) begin
            // well formed
        end else if (sel < 66) begin
            // other measurement type, rest ignored
            do b0 = 8'($urandom); while (b0[5:0] == pdfd_pkg::MEAS_TYPE);
            pkt[0] = b0;
            trim_to($urandom_range(1, 6));
        end else if (sel < 72) begin
            // wrong frame type, sometimes uncompressed as well
            pkt[pdfd_pkg::FRAME_POS] = 8'($urandom_range(1, 127)) |
                                       ($urandom_range(0, 1) ? 8'h80 : 8'h00);
            if ($urandom_range(0, 1))
                pkt[0][7] = 1'b0;
            trim_to($urandom_range(pdfd_pkg::FRAME_POS + 1, pdfd_pkg::FRAME_POS + 5));
        end else if (sel < 78) begin
            // uncompressed
            pkt[0][7] = 1'b0;
            trim_to($urandom_range(pdfd_pkg::FRAME_POS + 1, pdfd_pkg::FRAME_POS + 5));
        end else if (sel < 84) begin
            // frame size zero or too wide
            pkt[SIZE_POS] = $urandom_range(0, 2) == 0 ? 8'd0
                                                      : 8'($urandom_range(MAX_BITS + 1, 255));
            trim_to($urandom_range(SIZE_POS + 1, SIZE_POS + 4));
        end else if (sel < 94) begin
            // end mark anywhere before the natural end
            trim_to($urandom_range(1, pkt.size() - 1));
        end else begin
            trim_to($urandom_range(COUNT_POS + 1, COUNT_POS + 30));
        end
    endfunction

    // offer one byte item, idling beforehand at random
    task automatic send_item(logic [7:0] b, logic last);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_data_byte  <= b;
        s_packet_end <= last;
        do @(posedge aclk); while (!s_ready);
        sb.note_byte(b, last);
        items_sent++;
    endtask

    task automatic send_packet();
        foreach (pkt[i])
            send_item(pkt[i], i == pkt.size() - 1);
    endtask

    // result side: take items, stall at random, and once hold off long
    initial begin : result_sink
        ppg_result_t got;
        int          hold_left;
        bit          hold_done;
        hold_left = 0;
        hold_done = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                got.kind      = m_kind;
                got.code      = m_error_code;
                got.stamp     = m_stamp;
                got.sample_no = m_sample_index;
                got.green     = m_green_value;
                got.red       = m_red_value;
                got.infrared  = m_infrared_value;
                got.ambient   = m_ambient_value;
                got.run_last  = m_run_last;
                sb.check_result(got);
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (long_hold_req && !hold_done) begin
                // the sender keeps offering so the op queue fills and s_ready drops
                hold_left = LONG_HOLD;
                hold_done = 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
            end
        end
    end

    initial begin : stimulus
        sb = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // packet cut off right after byte 0
        pkt = {8'h81};
        send_packet();
        // other measurement type, ignored to the end mark
        pkt = {8'h02, 8'hFF};
        send_packet();
        // wrong frame type on an uncompressed packet, frame check wins
        pkt = {8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F};
        send_packet();
        // uncompressed, frame byte with only bit 7 set passes the frame check
        pkt = {8'h41, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80, 8'h80};
        send_packet();

        while (items_sent < TOTAL_ITEMS) begin
            // idle phases by progress: sender light, then receiver light, then none
            if (items_sent >= 2 * TOTAL_ITEMS / 3) begin
                src_idle_pct  = 0;
                sink_idle_pct <= 0;
            end else if (items_sent >= TOTAL_ITEMS / 3) begin
                src_idle_pct  = 57;
                sink_idle_pct <= 31;
                long_hold_req <= 1'b1;
            end
            make_packet();
            send_packet();
        end
        s_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge aclk);
        // room for a late result that nothing asked for
        repeat (40) @(posedge aclk);

        if (sb.fail_count == 0) begin
            $display("PASS ppg_delta_frame_decoder");
        end else begin
            $display("FAIL ppg_delta_frame_decoder");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
hw/rtl/pdfd_pkg.sv
hw/rtl/pdfd_front.sv
hw/rtl/pdfd_queue.sv
hw/rtl/pdfd_back.sv
hw/rtl/ppg_delta_frame_decoder.sv
sim/ppg_delta_frame_decoder_test.sv
